// File: design/mbps_pkg.sv
// Package for the masked byte pattern search core.
// Holds field widths, parameter defaults, register index codes and the result type.
// No dependencies; every other file of the block uses it by scoped names.
package mbps_pkg;

  // Field and register widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PAT_REG_W = 64;
  localparam int unsigned CARE_W    = 16;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned START_W   = 16;
  localparam int unsigned OFFSET_W  = 16;

  // Parameter defaults
  localparam int unsigned MAX_PATTERN_DEF = 16;
  localparam int unsigned MAX_BUFFER_DEF  = 65536;

  // Reset value of the care mask: every byte must match
  localparam logic [CARE_W-1:0] CARE_RESET = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW  = 3'd0,
    CFG_PATTERN_HIGH = 3'd1,
    CFG_CARE_MASK    = 3'd2,
    CFG_PATTERN_LEN  = 3'd3,
    CFG_SEARCH_START = 3'd4
  } cfg_idx_e;

  // One result beat
  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] found_offset;
  } result_t;

endpackage

// File: design/mbps_in_if.sv
// Input channel of the masked byte pattern search core: one buffer byte per beat.
// Depends on mbps_pkg for the byte width.
interface mbps_in_if;
  logic                        valid;
  logic                        ready;
  logic [mbps_pkg::BYTE_W-1:0] data_byte;
  logic                        last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: design/mbps_out_if.sv
// Result channel of the masked byte pattern search core: one search result per beat.
// Depends on mbps_pkg for the offset width.
interface mbps_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [mbps_pkg::OFFSET_W-1:0] found_offset;

  modport source (output valid, output found, output found_offset, input ready);
  modport sink   (input valid, input found, input found_offset, output ready);
endinterface

// File: design/masked_byte_pattern_search_core.sv
// Top level of the masked byte pattern search core.
// Depends on mbps_pkg, mbps_in_if, mbps_out_if, mbps_match and mbps_out_buf.
//
// Usage:
//   in_i carries one buffer byte per beat, last_byte marking the final byte.
//   res_o carries at most one result per buffer: found with the start offset
//   of the first match at or after search_start, or found=0 and offset 0 on
//   the last byte when nothing matched.
//   Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i while
//   the block is idle; writes take effect at the next edge.
// Throughput: one byte per cycle while in_i.ready is high. The window shift,
//   the masked compare and the position update all complete in the cycle
//   the byte is accepted. A result is registered in the result buffer and
//   appears on res_o once any result ahead of it has been taken.
// Stall: results queue in a two-entry buffer; in_i.ready drops while both
//   entries are full, which takes the receiver holding res_o.ready low.
// Reset: the position counter and done flag clear, the configuration takes
//   its reset values (care mask all ones, length zero) and the result buffer
//   empties. The byte window is not cleared.
module masked_byte_pattern_search_core #(
  parameter int unsigned MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
  parameter int unsigned MAX_BUFFER  = mbps_pkg::MAX_BUFFER_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mbps_pkg::CFG_W-1:0]       cfg_data_i,
  mbps_in_if.sink                          in_i,
  mbps_out_if.source                       res_o
);

  localparam int unsigned PW = $clog2(MAX_BUFFER + 1);
  localparam int unsigned CW = (PW > mbps_pkg::START_W) ? PW : mbps_pkg::START_W;
  localparam int unsigned LW = mbps_pkg::LEN_W;

  // Configuration registers
  logic [mbps_pkg::PAT_REG_W-1:0] pat_low_q;
  logic [mbps_pkg::PAT_REG_W-1:0] pat_high_q;
  logic [mbps_pkg::CARE_W-1:0]    care_q;
  logic [LW-1:0]                  pat_len_q;
  logic [mbps_pkg::START_W-1:0]   start_q;

  // Search state
  logic [MAX_PATTERN-1:0][mbps_pkg::BYTE_W-1:0] win_q, win_d;
  logic [PW-1:0]                                pos_q, pos_d;
  logic                                         done_q, done_d;

  logic              accept;
  logic [LW-1:0]     len_eff;
  logic              in_range;
  logic [CW-1:0]     pos_ext;
  logic [CW-1:0]     len_ext;
  logic [CW-1:0]     start_ofs;
  logic              win_match;
  logic              hit;
  logic              push;
  logic              buf_full;
  logic              buf_valid;
  mbps_pkg::result_t res_d;
  mbps_pkg::result_t buf_data;

  // Decode configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      care_q     <= mbps_pkg::CARE_RESET;
      pat_len_q  <= '0;
      start_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mbps_pkg::CFG_PATTERN_LOW:  pat_low_q  <= cfg_data_i;
        mbps_pkg::CFG_PATTERN_HIGH: pat_high_q <= cfg_data_i;
        mbps_pkg::CFG_CARE_MASK:    care_q     <= cfg_data_i[mbps_pkg::CARE_W-1:0];
        mbps_pkg::CFG_PATTERN_LEN:  pat_len_q  <= cfg_data_i[LW-1:0];
        mbps_pkg::CFG_SEARCH_START: start_q    <= cfg_data_i[mbps_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !buf_full;
  assign accept     = in_i.valid && in_i.ready;

  // Shift the new byte into the window, newest at age zero
  always_comb begin
    win_d[0] = in_i.data_byte;
    for (int a = 1; a < MAX_PATTERN; a++) begin
      win_d[a] = win_q[a-1];
    end
  end

  // Clamp length and form the candidate start offset
  assign len_eff   = (pat_len_q > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : pat_len_q;
  assign in_range  = (pos_q < PW'(MAX_BUFFER));
  assign pos_ext   = CW'(pos_q) + CW'(1);
  assign len_ext   = CW'(len_eff);
  assign start_ofs = pos_ext - len_ext;

  mbps_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .window_i  (win_d),
    .pattern_i ({pat_high_q, pat_low_q}),
    .care_i    (care_q),
    .len_i     (len_eff),
    .match_o   (win_match)
  );

  assign hit = !done_q && (len_eff != '0) && in_range && (pos_ext >= len_ext) &&
               (start_ofs >= CW'(start_q)) && win_match;

  // Emit a result on the first match, or on the last byte without one
  assign push               = accept && (hit || (in_i.last_byte && !done_q));
  assign res_d.found        = hit;
  assign res_d.found_offset = hit ? start_ofs[mbps_pkg::OFFSET_W-1:0] : '0;

  // Advance position and done flag, rearm after the last byte
  always_comb begin
    pos_d  = pos_q;
    done_d = done_q;
    if (accept) begin
      if (in_i.last_byte) begin
        pos_d  = '0;
        done_d = 1'b0;
      end else begin
        if (in_range) begin
          pos_d = pos_q + PW'(1);
        end
        if (hit) begin
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      done_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      done_q <= done_d;
    end
  end

  // Hold window bytes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

  mbps_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res_d),
    .full_o  (buf_full),
    .valid_o (buf_valid),
    .data_o  (buf_data),
    .pop_i   (res_o.ready)
  );

  assign res_o.valid        = buf_valid;
  assign res_o.found        = buf_data.found;
  assign res_o.found_offset = buf_data.found_offset;

  // Position never runs past the saturation point
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(MAX_BUFFER))
    else $error("byte position beyond buffer limit");

  // A last byte rearms the search for the next buffer
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.last_byte) |=> (pos_q == '0 && !done_q))
    else $error("search not rearmed after last byte");

  // Once a result is given, no other result comes from the same buffer
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && done_q) |-> !push)
    else $error("second result for one buffer");

  // A not-found result carries offset zero
  a_nf_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.found) |-> (res_o.found_offset == '0))
    else $error("not-found result with nonzero offset");

endmodule

// File: design/mbps_match.sv
// Masked compare of the newest window bytes against the stored pattern.
// Depends on mbps_pkg for widths. Purely combinational.
module mbps_match #(
  parameter int unsigned MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
  input  logic [MAX_PATTERN-1:0][mbps_pkg::BYTE_W-1:0] window_i,
  input  logic [2*mbps_pkg::PAT_REG_W-1:0]             pattern_i,
  input  logic [mbps_pkg::CARE_W-1:0]                  care_i,
  input  logic [mbps_pkg::LEN_W-1:0]                   len_i,
  output logic                                         match_o
);

  localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Pattern byte i lines up with the window byte of age len-1-i
  always_comb begin
    logic [mbps_pkg::LEN_W-1:0] age;
    match_o = 1'b1;
    age     = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      age = len_i - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(i);
      if ((mbps_pkg::LEN_W'(i) < len_i) && care_i[i]) begin
        if (window_i[age[AW-1:0]] != pattern_i[mbps_pkg::BYTE_W*i +: mbps_pkg::BYTE_W]) begin
          match_o = 1'b0;
        end
      end
    end
  end

endmodule

// File: design/mbps_out_buf.sv
// Two-entry result buffer between the search logic and the result channel.
// Depends on mbps_pkg for the result type.
module mbps_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mbps_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  output mbps_pkg::result_t data_o,
  input  logic              pop_i
);

  mbps_pkg::result_t [1:0] mem_q;
  logic                    wr_ptr_q, wr_ptr_d;
  logic                    rd_ptr_q, rd_ptr_d;
  logic [1:0]              count_q, count_d;
  logic                    do_pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold result payloads
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
